// ----- rtl/pdmc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdmc_pkg: shared types and constants of the microcell charge block
// sizes, field widths, item kinds, register indexes and module interfaces
// ----------------------------------------------------------------------------
`default_nettype none

package pdmc_pkg;

	localparam int CELLS         = 4096;
	localparam int TABLE_ENTRIES = 20;

	localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int TIDX_W  = $clog2(TABLE_ENTRIES);

	localparam int KIND_W   = 2;
	localparam int CELL_W   = 12;
	localparam int DRAW_W   = 16;
	localparam int ENTRY_W  = 5;
	localparam int VALUE_W  = 16;
	localparam int STEP_W   = 32;
	localparam int CHARGE_W = 48;
	localparam int THR_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int SCALE_W  = 32;
	localparam int POS_W    = STEP_W + SCALE_W;
	localparam int FRAC_W   = 16;

	localparam int CELL_EXT_W  = 17;
	localparam int ENTRY_EXT_W = 9;
	localparam int CELL_WORD_W = STEP_W + 1;

	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 80;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_PHOTON = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TABLE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd2;

	localparam logic TBL_EFF  = 1'b0;
	localparam logic TBL_VOLT = 1'b1;

	typedef struct packed {
		logic               en;
		logic               choice;
		logic [TIDX_W-1:0]  addr;
		logic [VALUE_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic              start;
		logic              sat;
		logic [TIDX_W-1:0] addr;
		logic [FRAC_W-1:0] frac;
	} lut_req_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] eff;
		logic [VALUE_W-1:0] volt;
	} lut_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/pdmc_ram.sv -----
// ----------------------------------------------------------------------------
// pdmc_ram: generic single-clock ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/pdmc_lut.sv -----
// ----------------------------------------------------------------------------
// pdmc_lut: efficiency and voltage tables with linear interpolation
// reads the two neighboring entries in turn and mixes them by the fraction
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_lut (
	input  logic               clk,
	input  logic               arst_n,
	input  pdmc_pkg::tbl_wr_t  wr,
	input  pdmc_pkg::lut_req_t req,
	output pdmc_pkg::lut_rsp_t rsp
);
	import pdmc_pkg::*;

	logic [TIDX_W-1:0]  addr_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               sat_q;
	logic [TIDX_W-1:0]  hi_addr;
	logic [TIDX_W-1:0]  raddr;
	logic [VALUE_W-1:0] eff_rd;
	logic [VALUE_W-1:0] vol_rd;
	logic [VALUE_W-1:0] lo_eff_q;
	logic [VALUE_W-1:0] lo_vol_q;
	logic [32:0]        m_eff_lo_q;
	logic [31:0]        m_eff_hi_q;
	logic [32:0]        m_vol_lo_q;
	logic [31:0]        m_vol_hi_q;
	logic [32:0]        weight_lo;
	logic [32:0]        eff_sum;
	logic [32:0]        vol_sum;
	logic [VALUE_W-1:0] eff_q;
	logic [VALUE_W-1:0] vol_q;
	logic               p1_q;
	logic               p2_q;
	logic               p3_q;
	logic               done_q;

	assign hi_addr = sat_q ? addr_q : addr_q + 1'b1;
	assign raddr   = p1_q ? hi_addr : req.addr;

	pdmc_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_ENTRIES)) u_eff_ram (
		.clk   (clk),
		.we    (wr.en && (wr.choice == TBL_EFF)),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (eff_rd)
	);

	pdmc_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_ENTRIES)) u_vol_ram (
		.clk   (clk),
		.we    (wr.en && (wr.choice == TBL_VOLT)),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (vol_rd)
	);

	always_comb begin
		weight_lo = 33'h10000 - 33'(frac_q);
		eff_sum   = m_eff_lo_q + 33'(m_eff_hi_q);
		vol_sum   = m_vol_lo_q + 33'(m_vol_hi_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q   <= 1'b0;
			p2_q   <= 1'b0;
			p3_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			p1_q   <= req.start;
			p2_q   <= p1_q;
			p3_q   <= p2_q;
			done_q <= p3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			addr_q <= req.addr;
			frac_q <= req.frac;
			sat_q  <= req.sat;
		end
		if (p1_q) begin
			lo_eff_q <= eff_rd;
			lo_vol_q <= vol_rd;
		end
		if (p2_q) begin
			m_eff_lo_q <= 33'(lo_eff_q) * weight_lo;
			m_eff_hi_q <= 32'(eff_rd) * 32'(frac_q);
			m_vol_lo_q <= 33'(lo_vol_q) * weight_lo;
			m_vol_hi_q <= 32'(vol_rd) * 32'(frac_q);
		end
		if (p3_q) begin
			eff_q <= sat_q ? lo_eff_q : eff_sum[31:16];
			vol_q <= sat_q ? lo_vol_q : vol_sum[31:16];
		end
	end

	assign rsp.done = done_q;
	assign rsp.eff  = eff_q;
	assign rsp.volt = vol_q;

endmodule

`default_nettype wire

// ----- rtl/photodetector_microcell_charge.sv -----
// ----------------------------------------------------------------------------
// photodetector_microcell_charge: microcell charge model of a photomultiplier
// per-cell fire step in a ram, table interpolation, saturating step charge
// ----------------------------------------------------------------------------
// photon beat: the next beat waits for the cell ram read, position multiply and
//   table unit, then the charge add if it fires; a cell fired this step skips them
// close beat: the result is registered in the emit state, which waits while the
//   previous result is held; table write, unused kind and bad cell take no further state
// reset: async, resets control and config registers, then a pass over every cell clears
//   the fired marks before the first beat is taken; config is taken throughout
`default_nettype none

module photodetector_microcell_charge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// cell_index, random_draw, table_choice, entry_index, entry_value
	input  logic [pdmc_pkg::S_DATA_W-1:0]       s_tdata,
	// kind
	input  logic [pdmc_pkg::KIND_W-1:0]         s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// step_charge, step_number
	output logic [pdmc_pkg::M_DATA_W-1:0]       m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pdmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pdmc_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_CELL  = 8'b00000100,
		S_POS   = 8'b00001000,
		S_LOOK  = 8'b00010000,
		S_WAIT  = 8'b00100000,
		S_ACC   = 8'b01000000,
		S_EMIT  = 8'b10000000
	} state_t;

	state_t state_q;

	logic [CELL_AW-1:0]     clr_addr_q;
	logic [THR_W-1:0]       thr_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [STEP_W-1:0]      step_q;
	logic [CHARGE_W-1:0]    charge_q;
	logic [CELL_AW-1:0]     cell_q;
	logic [DRAW_W-1:0]      draw_q;
	logic [STEP_W-1:0]      elapsed_q;
	logic                   recharged_q;
	logic [POS_W-1:0]       pos_q;
	logic [31:0]            add_q;
	logic                   add_en_q;
	logic                   out_valid_q;
	logic [CHARGE_W-1:0]    out_charge_q;
	logic [STEP_W-1:0]      out_step_q;

	logic [CELL_W-1:0]      in_cell;
	logic [DRAW_W-1:0]      in_draw;
	logic                   in_choice;
	logic [ENTRY_W-1:0]     in_entry;
	logic [VALUE_W-1:0]     in_value;
	logic [CELL_EXT_W-1:0]  cell_ext;
	logic [ENTRY_EXT_W-1:0] entry_ext;
	logic                   accept;
	logic                   clearing;
	logic                   fire_wr;
	logic                   cell_we;
	logic [CELL_AW-1:0]     cell_waddr;
	logic [CELL_WORD_W-1:0] cell_wdata;
	logic [CELL_WORD_W-1:0] cell_rdata;
	logic                   rd_fired;
	logic [STEP_W-1:0]      rd_last;
	logic                   pos_sat;
	logic [CHARGE_W:0]      charge_sum;
	tbl_wr_t                tbl_wr;
	lut_req_t               lut_req;
	lut_rsp_t               lut_rsp;

	assign in_cell   = s_tdata[11:0];
	assign in_draw   = s_tdata[27:12];
	assign in_choice = s_tdata[28];
	assign in_entry  = s_tdata[33:29];
	assign in_value  = s_tdata[49:34];
	assign cell_ext  = CELL_EXT_W'(in_cell);
	assign entry_ext = ENTRY_EXT_W'(in_entry);

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign clearing  = (state_q == S_CLEAR);
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_step_q, out_charge_q};

	// cell record: fired mark over the step of the last fire
	assign fire_wr    = (state_q == S_WAIT) && lut_rsp.done && (draw_q < lut_rsp.eff);
	assign cell_we    = clearing || fire_wr;
	assign cell_waddr = clearing ? clr_addr_q : cell_q;
	assign cell_wdata = clearing ? '0 : {1'b1, step_q};
	assign rd_fired   = cell_rdata[STEP_W];
	assign rd_last    = cell_rdata[STEP_W-1:0];

	pdmc_ram #(.WIDTH(CELL_WORD_W), .DEPTH(CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_ext[CELL_AW-1:0]),
		.rdata (cell_rdata)
	);

	always_comb begin
		tbl_wr.en     = accept && (s_tuser == KIND_TABLE) &&
			(32'(in_entry) < 32'(TABLE_ENTRIES));
		tbl_wr.choice = in_choice;
		tbl_wr.addr   = entry_ext[TIDX_W-1:0];
		tbl_wr.data   = in_value;

		pos_sat       = recharged_q ||
			(pos_q[POS_W-1:FRAC_W] >= (POS_W-FRAC_W)'(TABLE_ENTRIES - 1));
		lut_req.start = (state_q == S_LOOK);
		lut_req.sat   = pos_sat;
		lut_req.addr  = pos_sat ? TIDX_W'(TABLE_ENTRIES - 1) : pos_q[FRAC_W +: TIDX_W];
		lut_req.frac  = pos_q[FRAC_W-1:0];

		charge_sum    = {1'b0, charge_q} + (CHARGE_W+1)'(add_q);
	end

	pdmc_lut u_lut (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.req    (lut_req),
		.rsp    (lut_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			gain_q  <= GAIN_W'(1);
			scale_q <= SCALE_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
				REG_GAIN:      gain_q  <= cfg_data[GAIN_W-1:0];
				REG_SCALE:     scale_q <= cfg_data[SCALE_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			step_q      <= '0;
			charge_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (32'(clr_addr_q) == 32'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (s_tuser)
							KIND_PHOTON: begin
								if (32'(in_cell) < 32'(CELLS)) begin
									state_q <= S_CELL;
								end
							end
							KIND_CLOSE: state_q <= S_EMIT;
							default:    ;
						endcase
					end
				end
				S_CELL: begin
					if (rd_fired && (rd_last == step_q)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_POS;
					end
				end
				S_POS:  state_q <= S_LOOK;
				S_LOOK: state_q <= S_WAIT;
				S_WAIT: begin
					if (lut_rsp.done) begin
						state_q <= fire_wr ? S_ACC : S_IDLE;
					end
				end
				S_ACC: begin
					if (add_en_q) begin
						charge_q <= charge_sum[CHARGE_W] ? '1 : charge_sum[CHARGE_W-1:0];
					end
					state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						charge_q    <= '0;
						step_q      <= step_q + 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_q <= cell_ext[CELL_AW-1:0];
			draw_q <= in_draw;
		end
		if (state_q == S_CELL) begin
			recharged_q <= !rd_fired;
			elapsed_q   <= rd_fired ? step_q - rd_last : '0;
		end
		if (state_q == S_POS) begin
			pos_q <= POS_W'(elapsed_q) * POS_W'(scale_q);
		end
		if (fire_wr) begin
			add_q    <= 32'(lut_rsp.volt) * 32'(gain_q);
			add_en_q <= (lut_rsp.volt > thr_q);
		end
		if ((state_q == S_EMIT) && (!out_valid_q || m_tready)) begin
			out_charge_q <= charge_q;
			out_step_q   <= step_q;
		end
	end

endmodule

`default_nettype wire
